// File: hdl/ped_pkg.sv
package ped_pkg;
  localparam int PointsMax = 64;
  localparam int DimsMax = 16;
  localparam int CoordBits = 16;
  localparam int PtW = 6;
  localparam int DimW = 4;
  localparam int AddrW = PtW + DimW;
  localparam int DiffW = CoordBits + 1;
  localparam int SqW = 2 * CoordBits;
  localparam int SumW = SqW + DimW;
  localparam int DistW = 18;
  localparam int CntW = 7;
  localparam int DcntW = 5;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_ROW  = 1'b1;
  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_DIMS_IN_USE = 1'b1;

  typedef struct packed {
    logic clear_sum;
    logic rd_en;
    logic [PtW-1:0] row;
    logic [PtW-1:0] col;
    logic [DimW-1:0] dim;
    logic root_start;
  } ped_cmd_t;

  typedef struct packed {
    logic root_busy;
    logic root_done;
  } ped_sts_t;
endpackage

// File: hdl/ped_datapath.sv
module ped_datapath
  import ped_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [AddrW-1:0]     wr_addr,
  input  logic [CoordBits-1:0] wr_data,
  input  ped_cmd_t             cmd,
  output ped_sts_t             sts,
  output logic [DistW-1:0]     dist_val
);
  logic [CoordBits-1:0] mem_a [PointsMax*DimsMax];
  logic [CoordBits-1:0] mem_b [PointsMax*DimsMax];
  logic [CoordBits-1:0] a_r, b_r;
  logic                 rdv_r, sqv_r;
  logic [DiffW-1:0]     diff_r;
  logic                 dv_r;
  logic [SqW-1:0]       sq_r;
  logic [SumW-1:0]      sum_r;
  logic [SumW-1:0]      rem_r;
  logic [SumW-1:0]      root_r;
  logic                 busy_r, done_r;
  logic signed [DiffW-1:0] d;
  logic [SumW-1:0]      bit_r;
  logic [SumW-1:0]      cand;

  // two copies give two read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    a_r <= mem_a[{cmd.row, cmd.dim}];
    b_r <= mem_b[{cmd.col, cmd.dim}];
  end

  assign d = $signed({a_r[CoordBits-1], a_r}) - $signed({b_r[CoordBits-1], b_r});

  always_ff @(posedge clk) begin
    diff_r <= d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
    sq_r   <= SqW'(diff_r * diff_r);
    if (!rst_n) begin
      rdv_r <= 1'b0; dv_r <= 1'b0; sqv_r <= 1'b0;
    end else begin
      rdv_r <= cmd.rd_en;
      dv_r  <= rdv_r;
      sqv_r <= dv_r;
    end
    if (cmd.clear_sum) sum_r <= '0;
    else if (sqv_r) sum_r <= sum_r + SumW'(sq_r);
  end

  // restoring square root, one result bit per cycle
  assign cand = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.root_start) begin
        busy_r <= 1'b1;
        rem_r  <= sum_r;
        root_r <= '0;
        bit_r  <= SumW'(1) << (SumW - 2);
      end else if (busy_r) begin
        if (rem_r >= cand) begin
          rem_r  <= rem_r - cand;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[1:0] != 2'b00) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.root_busy = busy_r;
  assign sts.root_done = done_r;
  assign dist_val = (root_r > SumW'((1 << DistW) - 1)) ? '1 : DistW'(root_r);
endmodule

// File: hdl/ped_ctrl.sv
module ped_ctrl
  import ped_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [PtW-1:0]   row,
  input  logic [CntW-1:0]  npts,
  input  logic [DcntW-1:0] ndims,
  input  ped_sts_t         sts,
  input  logic             out_free,
  output ped_cmd_t         cmd,
  output logic             busy,
  output logic             res_valid,
  output logic [PtW-1:0]   res_row,
  output logic [PtW-1:0]   res_col,
  output logic             res_last
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_FEED = 5'b00010, S_DRAIN = 5'b00100,
    S_ROOT = 5'b01000, S_EMIT = 5'b10000
  } state_t;
  state_t state_r;
  logic [PtW-1:0] row_r, col_r;
  logic [DimW-1:0] dim_r;
  logic [1:0] drain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r <= '0; dim_r <= '0; drain_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) begin
          row_r <= row; col_r <= '0; dim_r <= '0; state_r <= S_FEED;
        end
        S_FEED: begin
          if (DcntW'(dim_r) + 1'b1 == ndims) begin
            dim_r <= '0; drain_r <= '0; state_r <= S_DRAIN;
          end else dim_r <= dim_r + 1'b1;
        end
        S_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == 2'd3) state_r <= S_ROOT;
        end
        S_ROOT: if (sts.root_done) state_r <= S_EMIT;
        S_EMIT: if (out_free) begin
          if (CntW'(col_r) + 1'b1 == npts) state_r <= S_IDLE;
          else begin
            col_r <= col_r + 1'b1; state_r <= S_FEED;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.row = row_r;
    cmd.col = col_r;
    cmd.dim = dim_r;
    cmd.rd_en = (state_r == S_FEED);
    cmd.clear_sum = (state_r == S_IDLE) || (state_r == S_EMIT);
    cmd.root_start = (state_r == S_DRAIN) && (drain_r == 2'd3);
  end

  assign busy = (state_r != S_IDLE);
  assign res_valid = (state_r == S_EMIT);
  assign res_row = row_r;
  assign res_col = col_r;
  assign res_last = CntW'(col_r) + 1'b1 == npts;
endmodule

// File: hdl/pairwise_euclidean_distance_unit.sv
// Pairwise Euclidean distance unit.
// Input stream beats either load one Q8.8 coordinate into the point store
// (tuser=0) or request a distance row for one point (tuser=1).
// A load returns nothing. A row request returns point_count beats, one per
// stored point in order, tlast on the final one. Each column walks
// dims_in_use coordinate pairs through a two-port read, subtract and
// multiply-accumulate, a drain state, an 18-step restoring square root, a
// step to see it finish and one to hand the result to the output register.
// A new input beat is taken only while no row is in flight, so a row holds
// off the input until its last result is in the output register. The
// output register holds a result until the receiver takes it; a stall
// simply stretches the row. Reset (rst_n low, synchronous) empties the
// pipeline and sets point_count=64, dims_in_use=16; the point store is not
// cleared and must be loaded before it is read. Configuration is written
// through cfg_wr_en/cfg_index/cfg_data; the user must write it only while
// idle, as the block does not enforce this.
module pairwise_euclidean_distance_unit
  import ped_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // point_index, dim_index, coordinate
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // row_index, column_index, distance
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  logic [CntW-1:0]  npts_r;
  logic [DcntW-1:0] ndims_r;
  ped_cmd_t cmd;
  ped_sts_t sts;
  logic [DistW-1:0] dist_val;
  logic busy, res_valid, res_last, start, acc, wr;
  logic [PtW-1:0] res_row, res_col;
  logic ovalid_r, olast_r;
  logic [31:0] odata_r;
  logic out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npts_r <= CntW'(64); ndims_r <= DcntW'(16);
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_POINT_COUNT)
        npts_r <= (cfg_data == '0) ? CntW'(1) : (cfg_data > 7'd64 ? CntW'(64) : cfg_data);
      else
        ndims_r <= (cfg_data[4:0] == '0) ? DcntW'(1) :
                   (cfg_data[4:0] > 5'd16 ? DcntW'(16) : cfg_data[4:0]);
    end
  end

  assign in_tready = !busy;
  assign acc = in_tvalid && in_tready;
  assign wr = acc && (in_tuser == REQ_LOAD);
  assign start = acc && (in_tuser == REQ_ROW);
  assign out_free = !ovalid_r || out_tready;

  // store address is point then dim, matching the read side
  ped_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .wr_en(wr), .wr_addr({in_tdata[5:0], in_tdata[9:6]}),
    .wr_data(in_tdata[25:10]), .cmd(cmd), .sts(sts), .dist_val(dist_val)
  );

  ped_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .row(in_tdata[5:0]),
    .npts(npts_r), .ndims(ndims_r), .sts(sts), .out_free(out_free),
    .cmd(cmd), .busy(busy), .res_valid(res_valid), .res_row(res_row),
    .res_col(res_col), .res_last(res_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (res_valid && out_free) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
    if (res_valid && out_free) begin
      odata_r <= {2'b00, dist_val, res_col, res_row};
      olast_r <= res_last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("input taken during row");
  a_root_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    sts.root_busy |-> busy) else $error("root outside row");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("beat dropped");
`endif
endmodule

// File: tb/pairwise_euclidean_distance_unit_tb.sv
module pairwise_euclidean_distance_unit_tb;
  import ped_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [5:0] pt;
    logic [3:0] dim;
    logic [15:0] coord;
  } req_beat_t;

  typedef struct packed {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [17:0] dval;
    logic        last;
  } dist_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  pairwise_euclidean_distance_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // shadow of the block
  logic signed [15:0] coord_mem [PointsMax][DimsMax];
  bit                 written [PointsMax][DimsMax];
  int unsigned        npoints;
  int unsigned        ndims;

  req_beat_t   pending_beats[$];
  dist_beat_t  expected_dists[$];
  int          errors;
  int          rows_seen;
  int          loads_sent;
  int          beats_out;
  longint      cycle_count;
  bit          hold_sender;
  int          long_stall;
  bit          cfg_busy;

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic predict_beat(input req_beat_t b);
    longint diff;
    logic [63:0] acc;
    logic [63:0] d;
    dist_beat_t r;
    if (b.kind == REQ_LOAD) begin
      coord_mem[b.pt][b.dim] = b.coord;
      return;
    end
    for (int j = 0; j < npoints; j++) begin
      acc = 0;
      for (int k = 0; k < ndims; k++) begin
        diff = longint'(coord_mem[b.pt][k]) - longint'(coord_mem[j][k]);
        acc = acc + 64'(diff * diff);
      end
      d = root_floor(acc);
      r.row = b.pt;
      r.col = j[5:0];
      r.dval = (d > 64'd262143) ? 18'h3FFFF : d[17:0];
      r.last = (j + 1 == npoints);
      expected_dists.push_back(r);
    end
  endtask

  // handshake sampled at the rising edge, consumed at the next falling edge
  logic in_tready_q;
  always @(posedge clk) in_tready_q <= in_tready && in_tvalid;

  // driver: bursts and gaps, fed from pending_beats
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready_q) begin
        predict_beat(pending_beats.pop_front());
      end
      if (in_tvalid && !in_tready_q) begin
        // keep offering the same beat
      end else if (pending_beats.size() > 0 && !hold_sender && gap_left == 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {6'd0, pending_beats[0].coord, pending_beats[0].dim, pending_beats[0].pt};
        in_tuser  <= pending_beats[0].kind;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 40);
      end else begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern
  int stall_mode;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_mode = 0;
    end else if (long_stall > 0) begin
      out_tready <= 1'b0;
      long_stall--;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    dist_beat_t got;
    dist_beat_t want;
    cycle_count++;
    if (rst_n && out_tvalid && out_tready) begin
      got.row  = out_tdata[5:0];
      got.col  = out_tdata[11:6];
      got.dval = out_tdata[29:12];
      got.last = out_tlast;
      beats_out++;
      if (expected_dists.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat row=%0d col=%0d dist=%0d last=%0d",
                 $time, got.row, got.col, got.dval, got.last);
      end else begin
        want = expected_dists.pop_front();
        if (got.last) rows_seen++;
        if (got !== want) begin
          errors++;
          $write("%0t: mismatch expected row=%0d col=%0d dist=%0d last=%0d, ",
                 $time, want.row, want.col, want.dval, want.last);
          $display("got row=%0d col=%0d dist=%0d last=%0d",
                   got.row, got.col, got.dval, got.last);
        end
      end
    end
    if (cycle_count > 64'd3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_beat_t load_beat(input int p, input int k, input logic [15:0] v);
    req_beat_t b;
    b.kind = REQ_LOAD; b.pt = p[5:0]; b.dim = k[3:0]; b.coord = v;
    written[p][k] = 1'b1;
    return b;
  endfunction

  function automatic req_beat_t row_beat(input int p);
    req_beat_t b;
    b.kind = REQ_ROW; b.pt = p[5:0]; b.dim = 4'($urandom); b.coord = 16'($urandom);
    return b;
  endfunction

  task automatic drain();
    while (pending_beats.size() > 0 || in_tvalid || expected_dists.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= val[6:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_POINT_COUNT) npoints = val;
    else ndims = val;
  endtask

  // every point below np gets its first nd dims written
  task automatic fill_points(input int np, input int nd, input bit extremes);
    logic [15:0] v;
    for (int p = 0; p < np; p++)
      for (int k = 0; k < nd; k++)
        if (!written[p][k] || $urandom_range(0, 3) == 0) begin
          v = extremes ? (($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000) : 16'($urandom);
          pending_beats.push_back(load_beat(p, k, v));
          loads_sent++;
        end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    hold_sender = 1'b0; long_stall = 0;
    errors = 0; rows_seen = 0; loads_sent = 0; beats_out = 0; cycle_count = 0;
    npoints = 64; ndims = 16;
    foreach (coord_mem[p, k]) begin
      coord_mem[p][k] = '0;
      written[p][k] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: small set, extremes of coordinates and indices
    write_reg(CFG_POINT_COUNT, 2);
    write_reg(CFG_DIMS_IN_USE, 1);
    pending_beats.push_back(load_beat(0, 0, 16'h7FFF));
    pending_beats.push_back(load_beat(1, 0, 16'h8000));
    pending_beats.push_back(row_beat(0));
    pending_beats.push_back(row_beat(1));
    pending_beats.push_back(load_beat(63, 15, 16'hFFFF));
    pending_beats.push_back(load_beat(1, 0, 16'h0000));
    pending_beats.push_back(row_beat(0));
    drain();
    // all dims with worst-case sums over eight points
    write_reg(CFG_DIMS_IN_USE, 16);
    write_reg(CFG_POINT_COUNT, 8);
    fill_points(8, 16, 1'b1);
    pending_beats.push_back(row_beat(7));
    pending_beats.push_back(row_beat(0));
    drain();
    // longest rows on a single dim
    write_reg(CFG_DIMS_IN_USE, 1);
    write_reg(CFG_POINT_COUNT, 64);
    fill_points(64, 1, 1'b0);
    pending_beats.push_back(row_beat(63));
    pending_beats.push_back(row_beat(0));
    drain();

    // random phases over the fully loaded points
    for (int ph = 0; ph < 6; ph++) begin
      int np;
      int nd;
      np = (ph == 5) ? 1 : $urandom_range(1, 8);
      nd = (ph == 4) ? 16 : $urandom_range(1, 16);
      write_reg(CFG_POINT_COUNT, np);
      write_reg(CFG_DIMS_IN_USE, nd);
      for (int it = 0; it < 30; it++) begin
        if ($urandom_range(0, 2) == 0) begin
          pending_beats.push_back(row_beat($urandom_range(0, np - 1)));
        end else begin
          int p;
          int k;
          p = $urandom_range(0, 63);
          k = $urandom_range(0, 15);
          pending_beats.push_back(load_beat(p, k, 16'($urandom)));
          loads_sent++;
        end
        if (it == 20 && ph == 1) long_stall = 3000;
      end
      if (ph == 2) begin
        hold_sender = 1'b1;
        while (expected_dists.size() > 0 || in_tvalid) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    $display("Rows checked: %0d, result beats: %0d, coordinate loads: %0d",
             rows_seen, beats_out, loads_sent);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/ped_pkg.sv
hdl/ped_datapath.sv
hdl/ped_ctrl.sv
hdl/pairwise_euclidean_distance_unit.sv
tb/pairwise_euclidean_distance_unit_tb.sv
